@@ rtl/core/pwls_pkg.sv @@
// Shared types and constants for the piecewise linear contrast stretch.
package pwls_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned DividendW = 17;  // 2*num + den, num <= 255*255
  localparam int unsigned DivisorW  = 9;   // 2*den
  localparam int unsigned QuoW      = 9;   // rounded quotient before clamp
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PixW-1:0] PixMax = '1;

  localparam logic [PixW-1:0] Break1XRst = 8'd50;
  localparam logic [PixW-1:0] Break1YRst = 8'd50;
  localparam logic [PixW-1:0] Break2XRst = 8'd200;
  localparam logic [PixW-1:0] Break2YRst = 8'd200;

  typedef enum logic [CfgIdxW-1:0] {
    RegBreak1X = 2'd0,
    RegBreak1Y = 2'd1,
    RegBreak2X = 2'd2,
    RegBreak2Y = 2'd3
  } pwls_reg_e;

  typedef struct packed {
    logic [PixW-1:0] break1_x;
    logic [PixW-1:0] break1_y;
    logic [PixW-1:0] break2_x;
    logic [PixW-1:0] break2_y;
  } pwls_cfg_t;

  // Partial division state handed from cell to cell.
  typedef struct packed {
    logic [DividendW-1:0] rem;
    logic [DivisorW-1:0]  dsr;
    logic [QuoW-1:0]      quo;
  } pwls_div_t;

endpackage

@@ rtl/core/pwls_front.sv @@
// Segment select and numerator/denominator stage ahead of the divider chain.
module pwls_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pwls_pkg::pwls_cfg_t          cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pwls_pkg::PixW-1:0]    pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pwls_pkg::pwls_div_t          out_data_o
);
  import pwls_pkg::*;

  logic [PixW-1:0]      xa, ya, xb, yb, den;
  logic [2*PixW-1:0]    prod_a, prod_b;
  logic [2*PixW:0]      num;
  logic [2*PixW+1:0]    dividend;
  logic                 force_max;
  logic                 valid_q;
  pwls_div_t            data_d, data_q;

  // Endpoints (xa,ya) to (xb,yb) of the segment the pixel falls on.
  always_comb begin
    force_max = 1'b0;
    xa = '0;
    ya = '0;
    xb = cfg_i.break1_x;
    yb = cfg_i.break1_y;
    priority if (pixel_i < cfg_i.break1_x) begin
      xa = '0;
    end else if (pixel_i < cfg_i.break2_x) begin
      xa = cfg_i.break1_x;
      ya = cfg_i.break1_y;
      xb = cfg_i.break2_x;
      yb = cfg_i.break2_y;
    end else if (cfg_i.break2_x == PixMax) begin
      force_max = 1'b1;
    end else begin
      xa = cfg_i.break2_x;
      ya = cfg_i.break2_y;
      xb = PixMax;
      yb = PixMax;
    end
  end

  assign den      = xb - xa;
  assign prod_a   = ya * (xb - pixel_i);
  assign prod_b   = yb * (pixel_i - xa);
  assign num      = {1'b0, prod_a} + {1'b0, prod_b};
  assign dividend = {num, 1'b0} + {{(PixW+2){1'b0}}, den};

  always_comb begin
    data_d.quo = '0;
    if (force_max) begin
      // 510 / 2 gives full scale
      data_d.rem = DividendW'({PixMax, 1'b0});
      data_d.dsr = DivisorW'(2);
    end else begin
      data_d.rem = dividend[DividendW-1:0];
      data_d.dsr = {den, 1'b0};
    end
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/core/pwls_div_cell.sv @@
// One restoring division step: decides quotient bit STEP and passes on.
module pwls_div_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pwls_pkg::pwls_div_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pwls_pkg::pwls_div_t    out_data_o
);
  import pwls_pkg::*;

  logic [DividendW:0] shifted;
  logic [DividendW:0] diff;
  logic               valid_q;
  pwls_div_t          data_d, data_q;

  assign shifted = (DividendW+1)'(in_data_i.dsr) << STEP;
  assign diff    = {1'b0, in_data_i.rem} - shifted;

  always_comb begin
    data_d = in_data_i;
    if (!diff[DividendW]) begin
      data_d.rem       = diff[DividendW-1:0];
      data_d.quo[STEP] = 1'b1;
    end
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/core/piecewise_linear_contrast_stretch.sv @@
// Top level of the piecewise linear contrast stretch.
//
// Usage:
//  - s_axis carries one 8-bit gray level per transaction; m_axis returns the
//    stretched level, one transaction out for every transaction in, in order.
//  - The curve runs (0,0) -> break1 -> break2 -> (255,255); the result is the
//    exact segment value rounded half up. Four break registers are written
//    through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while
//    the stream is idle, which the block itself does not enforce.
//  - Stages are one front stage (segment select, two 8x8 multiplies), nine
//    divider cells (one quotient bit each, restoring), a clamping output register.
//  - Throughput is one pixel per clock; every stage is a register with its
//    own valid bit, so a new pixel enters each cycle while the stream flows.
//  - When m_axis_tready is low, the output register holds its transaction and
//    the stages behind it keep filling until each holds a pixel; only then
//    does s_axis_tready drop.
//  - Reset empties the pipeline and loads break points (50,50) and (200,200).
module piecewise_linear_contrast_stretch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [pwls_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pwls_pkg::PixW-1:0]      cfg_data_i,
  // input pixels
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pwls_pkg::PixW-1:0]      s_axis_tdata,  // [7:0] pixel_in
  // stretched pixels
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pwls_pkg::PixW-1:0]      m_axis_tdata   // [7:0] pixel_out
);
  import pwls_pkg::*;

  pwls_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.break1_x <= Break1XRst;
      cfg_q.break1_y <= Break1YRst;
      cfg_q.break2_x <= Break2XRst;
      cfg_q.break2_y <= Break2YRst;
    end else if (cfg_we_i) begin
      unique case (pwls_reg_e'(cfg_idx_i))
        RegBreak1X: cfg_q.break1_x <= cfg_data_i;
        RegBreak1Y: cfg_q.break1_y <= cfg_data_i;
        RegBreak2X: cfg_q.break2_x <= cfg_data_i;
        RegBreak2Y: cfg_q.break2_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and payload links: link 0 leaves the front stage,
  // link k+1 leaves divider cell k.
  logic      link_valid [QuoW+1];
  logic      link_ready [QuoW+1];
  pwls_div_t link_data  [QuoW+1];

  pwls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pixel_i     (s_axis_tdata),
    .out_valid_o (link_valid[0]),
    .out_ready_i (link_ready[0]),
    .out_data_o  (link_data[0])
  );

  // Quotient bits are settled MSB first down the row.
  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    pwls_div_cell #(
      .STEP (QuoW - 1 - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[k]),
      .in_ready_o  (link_ready[k]),
      .in_data_i   (link_data[k]),
      .out_valid_o (link_valid[k+1]),
      .out_ready_i (link_ready[k+1]),
      .out_data_o  (link_data[k+1])
    );
  end

  // Output register with clamp to full scale.
  logic            out_valid_q;
  logic [PixW-1:0] out_data_q;
  logic [PixW-1:0] clamped;
  logic [QuoW-1:0] quo_last;

  assign quo_last         = link_data[QuoW].quo;
  assign clamped          = (quo_last > QuoW'(PixMax)) ? PixMax : quo_last[PixW-1:0];
  assign link_ready[QuoW] = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (link_ready[QuoW]) begin
      out_valid_q <= link_valid[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_ready[QuoW] && link_valid[QuoW]) begin
      out_data_q <= clamped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ tb/pwls_stream_checker.sv @@
// Scoreboard for the contrast stretch: tracks the curve, predicts and compares.
`timescale 1ns / 1ps
module pwls_stream_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pwls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pwls_pkg::PixW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [pwls_pkg::PixW-1:0]    in_pixel_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [pwls_pkg::PixW-1:0]    out_pixel_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import pwls_pkg::*;

  localparam int unsigned TopLevel = 255;

  pwls_cfg_t       curve;
  logic [PixW-1:0] expected_levels[$];
  int              out_index;

  assign pending_o = expected_levels.size();

  function automatic int unsigned round_half_up(input int unsigned num, input int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [PixW-1:0] stretch_level(input logic [PixW-1:0] p,
                                                    input pwls_cfg_t c);
    int unsigned x1, y1, x2, y2, lvl, pv;
    x1 = c.break1_x;
    y1 = c.break1_y;
    x2 = c.break2_x;
    y2 = c.break2_y;
    pv = p;
    if (pv < x1) begin
      lvl = round_half_up(y1 * pv, x1);
    end else if (pv < x2) begin
      lvl = round_half_up(y1 * (x2 - pv) + y2 * (pv - x1), x2 - x1);
    end else if (x2 >= TopLevel) begin
      lvl = TopLevel;
    end else begin
      lvl = round_half_up(y2 * (TopLevel - pv) + TopLevel * (pv - x2), TopLevel - x2);
    end
    if (lvl > TopLevel) lvl = TopLevel;
    return lvl[PixW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [PixW-1:0] want;
    if (!rst_ni) begin
      curve.break1_x = Break1XRst;
      curve.break1_y = Break1YRst;
      curve.break2_x = Break2XRst;
      curve.break2_y = Break2YRst;
      expected_levels.delete();
      out_index = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("output #%0d (pixel_out=%0d) with nothing expected",
                                    out_index, out_pixel_i));
        end else begin
          want = expected_levels.pop_front();
          if (out_pixel_i !== want)
            report_mismatch($sformatf("output #%0d pixel_out=%0d, expected %0d",
                                      out_index, out_pixel_i, want));
        end
        out_index++;
      end
      // prediction uses the curve in force before any write at this edge
      if (in_valid_i && in_ready_i)
        expected_levels.push_back(stretch_level(in_pixel_i, curve));
      if (cfg_we_i) begin
        case (pwls_reg_e'(cfg_idx_i))
          RegBreak1X: curve.break1_x = cfg_data_i;
          RegBreak1Y: curve.break1_y = cfg_data_i;
          RegBreak2X: curve.break2_x = cfg_data_i;
          RegBreak2Y: curve.break2_y = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/tb_piecewise_linear_contrast_stretch.sv @@
// Top of the contrast stretch testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_piecewise_linear_contrast_stretch;
  import pwls_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RandPhases   = 8;
  localparam int PhaseItems   = 225;   // 8 x 225 = 1800 random pixels
  localparam int SettleCycles = 30;    // idle wait after the drain, longer than the pipeline latency

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [PixW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata;   // [7:0] pixel_in
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [PixW-1:0]     m_axis_tdata;   // [7:0] pixel_out

  int fail_count;
  int pending;
  int cycles;

  // per-side idling switches; when quiet, that side never idles
  bit src_quiet;
  bit snk_quiet;

  // current break x levels, used to aim pixels at the segment edges
  logic [PixW-1:0] cur_x1;
  logic [PixW-1:0] cur_x2;

  piecewise_linear_contrast_stretch dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pwls_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_pixel_i   (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pixel_i  (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sink side: before each transaction, hold tready low for a random wait (none
  // when snk_quiet), then keep it high until the output transaction goes through.
  initial begin
    int w;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = snk_quiet ? 0 : $urandom_range(0, 14);
      repeat (w) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  // One input transaction with a random leading gap. tvalid is left high
  // afterwards so back-to-back pixels keep it up without a glitch.
  task automatic send_pixel(input logic [PixW-1:0] p);
    int w;
    w = src_quiet ? 0 : $urandom_range(0, 14);
    repeat (w) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted pixel has come back.
  task automatic drain_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Load a new curve; only done with the pipeline empty.
  task automatic load_curve(input logic [PixW-1:0] x1, input logic [PixW-1:0] y1,
                            input logic [PixW-1:0] x2, input logic [PixW-1:0] y2);
    pwls_reg_e       idx[4];
    logic [PixW-1:0] val[4];
    drain_stream();
    idx = '{RegBreak1X, RegBreak1Y, RegBreak2X, RegBreak2Y};
    val = '{x1, y1, x2, y2};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_x1 = x1;
    cur_x2 = x2;
  endtask

  // break levels lean toward the extremes
  function automatic logic [PixW-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PixMax;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // pixels: mostly uniform, some on either side of a break, some at the rails
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return cur_x1 + PixW'($urandom_range(0, 2)) - 8'd1;
      1:       return cur_x2 + PixW'($urandom_range(0, 2)) - 8'd1;
      2:       return $urandom_range(0, 1) ? PixMax : '0;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [PixW-1:0] dir_reset[8];
    logic [PixW-1:0] dir_edge[5];
    logic [PixW-1:0] dir_swap[4];
    logic [PixW-1:0] dir_fall[5];

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegBreak1X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_quiet     = 1'b0;
    snk_quiet     = 1'b0;
    cur_x1        = Break1XRst;
    cur_x2        = Break2XRst;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset curve, both break points from each side and the rails
    dir_reset = '{8'd0, 8'd49, 8'd50, 8'd51, 8'd199, 8'd200, 8'd254, 8'd255};
    foreach (dir_reset[i]) send_pixel(dir_reset[i]);

    // break1 at zero (first segment unused), break2 at the top (pixel 255 pinned)
    load_curve(8'd0, 8'd0, 8'd255, 8'd255);
    dir_edge = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
    foreach (dir_edge[i]) send_pixel(dir_edge[i]);

    // break points out of order: middle segment never taken
    load_curve(8'd200, 8'd10, 8'd100, 8'd240);
    dir_swap = '{8'd0, 8'd199, 8'd200, 8'd255};
    foreach (dir_swap[i]) send_pixel(dir_swap[i]);

    // falling middle segment
    load_curve(8'd60, 8'd255, 8'd180, 8'd0);
    dir_fall = '{8'd59, 8'd60, 8'd120, 8'd180, 8'd255};
    foreach (dir_fall[i]) send_pixel(dir_fall[i]);

    // Random phases; the first few use fixed corner curves
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       load_curve(8'd255, 8'd255, 8'd255, 8'd0);
        1:       load_curve(8'd1, 8'd255, 8'd254, 8'd0);
        2:       load_curve(8'd0, 8'd255, 8'd0, 8'd0);
        default: load_curve(pick_level(), pick_level(), pick_level(), pick_level());
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // re-roll idling every 40 pixels so quiet stretches mix with gaps
        if (n % 40 == 0) begin
          src_quiet = ($urandom_range(0, 3) == 0);
          snk_quiet = ($urandom_range(0, 3) == 0);
        end
        // hold-off: let the pipeline run dry mid-phase
        if (n == PhaseItems / 2) drain_stream();
        send_pixel(pick_pixel());
      end
    end

    drain_stream();
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
